// File: rtl/sktg_pkg.sv
// ---------------------------------------------------------------------------
// sktg_pkg: shared types, codes and table math for the keyed tone generator
// Holds the command and register codes, the job flag struct that travels
// from the front end to the sample back end, and the constant functions
// that build the cosine and edge tables at elaboration.
// ---------------------------------------------------------------------------
package sktg_pkg;

  // Port widths fixed by the interface
  localparam int SEG_LEN_W  = 24;
  localparam int SAMPLE_W   = 16;
  localparam int PHASE_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Queue depths
  localparam int MIDQ_DEPTH = 4;
  localparam int OUTQ_DEPTH = 8;

  // Command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // Mode codes
  localparam logic MODE_OOK = 1'b0;
  localparam logic MODE_FSK = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CARRIER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT   = 2'd2;

  // Fixed-point constants
  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
  localparam longint          ONE_Q30     = 64'sd1073741824;

  // Flags of one sample job
  typedef struct packed {
    logic idle;     // ticked with no active segment
    logic tone;     // carrier sounds on this sample
    logic last;     // final sample of the segment
    logic rise_en;  // apply the rise weight
    logic fall_en;  // apply the fall weight
  } job_flags_t;

  localparam int JOB_FLAGS_W = $bits(job_flags_t);

  // Cosine of x (Q30 radians, 0..pi/2) as a Taylor series, clamped to [0, 1]
  function automatic longint series_cos(input longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    x2   = (x * x) >> 30;
    term = longint'(ONE_Q30);
    sum  = ONE_Q30;
    term = ((term * x2) >> 30) / 2;   sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 12;  sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 30;  sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 56;  sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 90;  sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 132; sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 182; sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 240; sum = sum + longint'(term);
    if (sum < 0) sum = 0;
    if (sum > ONE_Q30) sum = ONE_Q30;
    return sum;
  endfunction

  // Cosine of a turn fraction, signed Q30
  function automatic longint cos_q30(input logic [31:0] phase);
    longint unsigned x;
    longint unsigned xc;
    longint          r;
    x  = (longint'(phase[29:0]) * PI_HALF_Q30) >> 30;
    xc = PI_HALF_Q30 - x;
    unique case (phase[31:30])
      2'd0: r = series_cos(x);
      2'd1: r = -series_cos(xc);
      2'd2: r = -series_cos(x);
      default: r = series_cos(xc);
    endcase
    return r;
  endfunction

  // Q15 cosine magnitude of a quadrant fraction; mirror takes pi/2 - x
  function automatic logic [15:0] cos_mag_q15(input logic [31:0] frac, input logic mirror);
    longint unsigned x;
    longint          c;
    x = (longint'(frac[29:0]) * PI_HALF_Q30) >> 30;
    c = mirror ? series_cos(PI_HALF_Q30 - x) : series_cos(x);
    return 16'((c * 64'sd32767 + 64'sd536870912) >>> 30);
  endfunction

  // Round-half-up Q15 scale of a signed sample by an unsigned weight
  function automatic logic signed [15:0] mul_q15(input logic signed [15:0] s,
                                                 input logic [15:0] w);
    logic signed [32:0] p;
    p = 33'(s) * $signed({17'd0, w}) + 33'sd16384;
    return p[30:15];
  endfunction

endpackage

// File: rtl/sktg_fifo.sv
// ---------------------------------------------------------------------------
// sktg_fifo: small register queue
// Holds up to DEPTH beats of WIDTH bits; the head is shown while not empty.
// ---------------------------------------------------------------------------
module sktg_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the incoming beat
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// File: rtl/sktg_front.sv
// ---------------------------------------------------------------------------
// sktg_front: command front end
// Takes start and tick commands, keeps the segment state and the phase
// accumulator, and issues one sample job per tick to the job queue.
// ---------------------------------------------------------------------------
module sktg_front #(
  parameter int EDGE_LEN      = 64,
  parameter int COS_ADDR_BITS = 10,
  parameter int LEN_BITS      = 24,
  parameter int EW            = 6
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // command beats
  input  logic                                cmd_valid,
  input  logic                                cmd_command,
  input  logic                                cmd_key_down,
  input  logic [sktg_pkg::SEG_LEN_W-1:0]      cmd_seg_len,
  // register writes
  input  logic                                cfg_we,
  input  logic [sktg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sktg_pkg::CFG_DATA_W-1:0]     cfg_data,
  // job beats
  output logic                                job_push,
  output sktg_pkg::job_flags_t                job_flags,
  output logic [COS_ADDR_BITS-1:0]            job_cos_addr,
  output logic [EW-1:0]                       job_rise_idx,
  output logic [EW-1:0]                       job_fall_idx
);

  import sktg_pkg::*;

  logic                mode_r;
  logic [PHASE_W-1:0]  carrier_r;
  logic [PHASE_W-1:0]  shift_r;

  logic [PHASE_W-1:0]  phase_r, phase_nxt;
  logic [LEN_BITS-1:0] idx_r, idx_nxt;
  logic [LEN_BITS-1:0] len_r, len_nxt;
  logic                key_r, key_nxt;
  logic                active_r, active_nxt;

  logic [LEN_BITS-1:0] len_in;
  logic [LEN_BITS-1:0] idx_inc;
  logic [LEN_BITS-1:0] rem;
  logic [31:0]         idx_ext;
  logic [31:0]         rem_ext;
  logic [PHASE_W-1:0]  step;
  logic [PHASE_W-1:0]  phase_adv;
  logic                tone;
  logic                is_last;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_OOK;
      carrier_r <= '0;
      shift_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:    mode_r    <= cfg_data[0];
        CFG_CARRIER: carrier_r <= cfg_data;
        CFG_SHIFT:   shift_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Segment arithmetic for the current tick
  assign len_in    = LEN_BITS'(cmd_seg_len);
  assign idx_inc   = idx_r + 1'b1;
  assign rem       = len_r - idx_r;
  assign idx_ext   = 32'(idx_r);
  assign rem_ext   = 32'(rem);
  assign tone      = (mode_r == MODE_FSK) || key_r;
  assign step      = carrier_r + (((mode_r == MODE_FSK) && key_r) ? shift_r : '0);
  assign phase_adv = phase_r + step;
  assign is_last   = (idx_inc == len_r);

  // Next segment state
  always_comb begin
    phase_nxt  = phase_r;
    idx_nxt    = idx_r;
    len_nxt    = len_r;
    key_nxt    = key_r;
    active_nxt = active_r;
    if (cmd_valid) begin
      unique case (cmd_command)
        CMD_START: begin
          key_nxt    = cmd_key_down;
          len_nxt    = len_in;
          idx_nxt    = '0;
          active_nxt = (len_in != '0);
        end
        default: begin
          if (active_r) begin
            if (tone) begin
              phase_nxt = phase_adv;
            end
            idx_nxt = idx_inc;
            if (is_last) begin
              active_nxt = 1'b0;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= '0;
      idx_r    <= '0;
      len_r    <= '0;
      key_r    <= 1'b0;
      active_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      idx_r    <= idx_nxt;
      len_r    <= len_nxt;
      key_r    <= key_nxt;
      active_r <= active_nxt;
    end
  end

  // Classify the tick into a job
  assign job_push          = cmd_valid && (cmd_command == CMD_TICK);
  assign job_flags.idle    = !active_r;
  assign job_flags.tone    = active_r && tone;
  assign job_flags.last    = active_r && is_last;
  assign job_flags.rise_en = active_r && tone && (idx_ext < 32'(EDGE_LEN));
  assign job_flags.fall_en = active_r && tone && (rem_ext < 32'(EDGE_LEN));
  assign job_cos_addr      = phase_adv[PHASE_W-1 -: COS_ADDR_BITS];
  assign job_rise_idx      = idx_ext[EW-1:0];
  assign job_fall_idx      = rem_ext[EW-1:0];

endmodule

// File: rtl/sktg_back.sv
// ---------------------------------------------------------------------------
// sktg_back: sample back end
// Pops jobs, looks up the quarter-wave cosine and the edge weights, applies
// the rise and fall scaling in two multiply stages and queues the results.
// ---------------------------------------------------------------------------
module sktg_back #(
  parameter int EDGE_LEN      = 64,
  parameter int COS_ADDR_BITS = 10,
  parameter int EW            = 6
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // job beats
  input  logic                              job_empty,
  output logic                              job_pop,
  input  sktg_pkg::job_flags_t              job_flags,
  input  logic [COS_ADDR_BITS-1:0]          job_cos_addr,
  input  logic [EW-1:0]                     job_rise_idx,
  input  logic [EW-1:0]                     job_fall_idx,
  // result beats
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic signed [sktg_pkg::SAMPLE_W-1:0] out_sample,
  output logic                              out_last_of_segment,
  output logic                              out_idle
);

  import sktg_pkg::*;

  localparam int QW     = COS_ADDR_BITS - 2;
  localparam int QDEPTH = 1 << QW;
  localparam int CRW    = $clog2(OUTQ_DEPTH + 1);
  localparam int OQW    = SAMPLE_W + 2;

  // Constant tables
  logic [15:0] cos_lo_rom [QDEPTH];
  logic [15:0] cos_hi_rom [QDEPTH];
  logic [15:0] edge_rom   [EDGE_LEN];

  for (genvar g = 0; g < QDEPTH; g++) begin : g_cos
    localparam logic [31:0] FRAC = 32'(g) << (32 - COS_ADDR_BITS);
    localparam logic [15:0] LO   = cos_mag_q15(FRAC, 1'b0);
    localparam logic [15:0] HI   = cos_mag_q15(FRAC, 1'b1);
    assign cos_lo_rom[g] = LO;
    assign cos_hi_rom[g] = HI;
  end

  for (genvar g = 0; g < EDGE_LEN; g++) begin : g_edge
    localparam longint unsigned P1 = (longint'(g) << 31) / EDGE_LEN;
    localparam longint unsigned P2 = (longint'(g) << 32) / EDGE_LEN;
    localparam longint NUM  = 42 * ONE_Q30 - 50 * cos_q30(32'(P1)) + 8 * cos_q30(32'(P2));
    localparam longint NUMC = (NUM < 0) ? 64'sd0 : NUM;
    localparam longint W    = (NUMC * 32768 + 50 * ONE_Q30) / (100 * ONE_Q30);
    localparam logic [15:0] WQ = (W > 32767) ? 16'd32767 : 16'(W);
    assign edge_rom[g] = WQ;
  end

  logic [CRW-1:0]        credit_r, credit_nxt;
  logic                  issue;
  logic                  res_pop;

  logic                  v1_r, v2_r, v3_r;
  job_flags_t            flags1_r, flags2_r;
  logic [15:0]           mag1_r;
  logic                  neg1_r;
  logic [15:0]           rise_w1_r, fall_w1_r, fall_w2_r;
  logic signed [15:0]    s1;
  logic signed [15:0]    s2_r;
  logic signed [15:0]    s3;
  logic signed [15:0]    s3_r;
  logic                  last3_r, idle3_r;

  logic [1:0]            quad;
  logic [QW-1:0]         qaddr;

  logic                  outq_full;
  logic [OQW-1:0]        outq_rdata;

  // Issue a job only while the result queue has room for everything in flight
  assign issue   = !job_empty && (credit_r < CRW'(OUTQ_DEPTH));
  assign job_pop = issue;
  assign res_pop = out_pop && !out_empty;

  always_comb begin
    credit_nxt = credit_r;
    if (issue && !res_pop) begin
      credit_nxt = credit_r + 1'b1;
    end else if (res_pop && !issue) begin
      credit_nxt = credit_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= '0;
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      v3_r     <= 1'b0;
    end else begin
      credit_r <= credit_nxt;
      v1_r     <= issue;
      v2_r     <= v1_r;
      v3_r     <= v2_r;
    end
  end

  // Stage 1: table lookups
  assign quad  = job_cos_addr[COS_ADDR_BITS-1 -: 2];
  assign qaddr = job_cos_addr[QW-1:0];

  always_ff @(posedge clk) begin
    flags1_r  <= job_flags;
    mag1_r    <= quad[0] ? cos_hi_rom[qaddr] : cos_lo_rom[qaddr];
    neg1_r    <= quad[1] ^ quad[0];
    rise_w1_r <= edge_rom[job_rise_idx];
    fall_w1_r <= edge_rom[job_fall_idx];
  end

  // Stage 2: sign and rise scaling
  assign s1 = neg1_r ? -$signed(mag1_r) : $signed(mag1_r);

  always_ff @(posedge clk) begin
    flags2_r  <= flags1_r;
    fall_w2_r <= fall_w1_r;
    s2_r      <= flags1_r.rise_en ? mul_q15(s1, rise_w1_r) : s1;
  end

  // Stage 3: fall scaling, silence for OOK key-up and idle ticks
  assign s3 = flags2_r.fall_en ? mul_q15(s2_r, fall_w2_r) : s2_r;

  always_ff @(posedge clk) begin
    s3_r    <= flags2_r.tone ? s3 : '0;
    last3_r <= flags2_r.last;
    idle3_r <= flags2_r.idle;
  end

  // Result queue
  sktg_fifo #(
    .WIDTH (OQW),
    .DEPTH (OUTQ_DEPTH)
  ) u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (v3_r),
    .wdata ({s3_r, last3_r, idle3_r}),
    .full  (outq_full),
    .pop   (out_pop),
    .rdata (outq_rdata),
    .empty (out_empty)
  );

  assign out_sample          = $signed(outq_rdata[OQW-1 -: SAMPLE_W]);
  assign out_last_of_segment = outq_rdata[1];
  assign out_idle            = outq_rdata[0];

  // Checks
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> !outq_full) else $error("result beat pushed into a full queue");

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    credit_r <= CRW'(OUTQ_DEPTH)) else $error("credit count overran the queue depth");

  a_credit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (credit_r == '0) |-> (out_empty && !v1_r && !v2_r && !v3_r))
    else $error("beat in flight with no credit taken");

  a_job_class: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> !(flags1_r.idle && (flags1_r.tone || flags1_r.last)))
    else $error("idle job also marked as tone or last");

endmodule

// File: rtl/shaped_keyed_tone_generator_top.sv
// ---------------------------------------------------------------------------
// shaped_keyed_tone_generator_top: keyed carrier with Blackman edge shaping
// A tick's result goes through the job queue, the back end stages and the
// result queue. Throughput: one command per cycle while in_full is low; a
// start gives no result. The front end phase accumulator add sets the rate.
// Reset: synchronous, active low; clears segment state, phase, registers and
// queues. Tables are constant logic and need no fill after reset.
// ---------------------------------------------------------------------------
module shaped_keyed_tone_generator_top #(
  parameter int EDGE_LEN      = 64,
  parameter int COS_ADDR_BITS = 10,
  parameter int LEN_BITS      = 24
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // command queue side
  input  logic                                  in_push,
  output logic                                  in_full,
  input  logic                                  in_command,
  input  logic                                  in_key_down,
  input  logic [sktg_pkg::SEG_LEN_W-1:0]        in_seg_len,
  // result queue side
  output logic                                  out_empty,
  input  logic                                  out_pop,
  output logic signed [sktg_pkg::SAMPLE_W-1:0]  out_sample,
  output logic                                  out_last_of_segment,
  output logic                                  out_idle,
  // register writes
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [sktg_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [sktg_pkg::CFG_DATA_W-1:0]       cfg_data
);

  import sktg_pkg::*;

  localparam int EW  = (EDGE_LEN > 1) ? $clog2(EDGE_LEN) : 1;
  localparam int JQW = JOB_FLAGS_W + COS_ADDR_BITS + 2 * EW;

  logic                     cmd_valid;
  logic                     job_push, job_pop, job_empty;
  job_flags_t               f_flags, b_flags;
  logic [COS_ADDR_BITS-1:0] f_cos_addr, b_cos_addr;
  logic [EW-1:0]            f_rise_idx, b_rise_idx;
  logic [EW-1:0]            f_fall_idx, b_fall_idx;
  logic [JQW-1:0]           jq_rdata;

  assign cmd_valid = in_push && !in_full;
  assign cfg_ready = 1'b1;

  // Front end
  sktg_front #(
    .EDGE_LEN      (EDGE_LEN),
    .COS_ADDR_BITS (COS_ADDR_BITS),
    .LEN_BITS      (LEN_BITS),
    .EW            (EW)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (cmd_valid),
    .cmd_command  (in_command),
    .cmd_key_down (in_key_down),
    .cmd_seg_len  (in_seg_len),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .job_push     (job_push),
    .job_flags    (f_flags),
    .job_cos_addr (f_cos_addr),
    .job_rise_idx (f_rise_idx),
    .job_fall_idx (f_fall_idx)
  );

  // Job queue between front and back
  sktg_fifo #(
    .WIDTH (JQW),
    .DEPTH (MIDQ_DEPTH)
  ) u_jobq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .wdata ({f_flags, f_cos_addr, f_rise_idx, f_fall_idx}),
    .full  (in_full),
    .pop   (job_pop),
    .rdata (jq_rdata),
    .empty (job_empty)
  );

  assign {b_flags, b_cos_addr, b_rise_idx, b_fall_idx} = jq_rdata;

  // Back end
  sktg_back #(
    .EDGE_LEN      (EDGE_LEN),
    .COS_ADDR_BITS (COS_ADDR_BITS),
    .EW            (EW)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .job_empty           (job_empty),
    .job_pop             (job_pop),
    .job_flags           (b_flags),
    .job_cos_addr        (b_cos_addr),
    .job_rise_idx        (b_rise_idx),
    .job_fall_idx        (b_fall_idx),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_sample          (out_sample),
    .out_last_of_segment (out_last_of_segment),
    .out_idle            (out_idle)
  );

endmodule
